// ===== rtl/core/emc_pkg.sv =====
// Shared constants for the energy counter power meter.
package emc_pkg;

	// Register defaults.
	localparam logic [31:0] MIN_INTERVAL_RST = 32'd100000;
	localparam logic [31:0] MAX_INTERVAL_RST = 32'd10000000;
	localparam logic [23:0] MAX_POWER_RST    = 24'd1000000;
	localparam logic [4:0]  WINDOW_LEN_RST   = 5'd10;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MIN_INTERVAL = 2'd0;
	localparam logic [1:0] CFG_MAX_INTERVAL = 2'd1;
	localparam logic [1:0] CFG_MAX_POWER    = 2'd2;
	localparam logic [1:0] CFG_WINDOW_LEN   = 2'd3;

	// Parameter defaults.
	localparam int NUM_DOMAINS_DEF = 8;
	localparam int RING_DEPTH_DEF  = 16;

	// Shared divider widths.
	localparam int DIV_NW = 64;
	localparam int DIV_DW = 32;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	// Milliwatt scale of uJ/us.
	localparam logic [9:0] MW_SCALE = 10'd1000;

endpackage

// ===== rtl/core/emc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module emc_div import emc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	logic              busy_q, done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW:0]   sh, diff;
	logic              ge;

	// One shift-subtract step.
	always_comb begin
		sh   = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
		ge   = sh >= {1'b0, dvs_q};
		diff = sh - {1'b0, dvs_q};
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff : sh;
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/energy_counter_power_meter.sv =====
// Top level: per-domain record memory, reading ring memory and sequencer.
//
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    domain, energy_cnt, time_us
// out      out  out_valid/out_ready  out_domain .. total_energy_uj
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time: an item that yields a result makes three passes
// through the shared divider (power, window average, session average).
// A first sample only seeds its record; a rejected one stops at a limit check.
// Reset clears seen bits, state and config registers; no clearing pass needed.
// A result waits in the output register; the next item is taken meanwhile.
module energy_counter_power_meter import emc_pkg::*; #(
	parameter int NUM_DOMAINS = NUM_DOMAINS_DEF,
	parameter int RING_DEPTH  = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  domain,
	input  logic [31:0] energy_cnt,
	input  logic [63:0] time_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_domain,
	output logic [23:0] window_avg_mw,
	output logic [31:0] counter_uj,
	output logic [23:0] min_avg_mw,
	output logic [23:0] max_avg_mw,
	output logic [23:0] session_avg_mw,
	output logic [63:0] total_energy_uj,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int DW   = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
	localparam int HW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FW   = $clog2(RING_DEPTH + 1);
	localparam int RD   = NUM_DOMAINS * RING_DEPTH;
	localparam int RW   = (RD > 1) ? $clog2(RD) : 1;
	localparam int SUMW = 24 + FW;

	typedef struct packed {
		logic [31:0]   prev_energy;
		logic [63:0]   prev_time;
		logic [HW-1:0] head;
		logic [FW-1:0] fill;
		logic [23:0]   min_p;
		logic [23:0]   max_p;
		logic [63:0]   avg_sum;
		logic [31:0]   avg_count;
		logic [63:0]   total;
	} rec_t;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOAD = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_PDIV = 4'd3;
	localparam logic [3:0] S_RRD  = 4'd4;
	localparam logic [3:0] S_RACC = 4'd5;
	localparam logic [3:0] S_WDIV = 4'd6;
	localparam logic [3:0] S_SGO  = 4'd7;
	localparam logic [3:0] S_SDIV = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	// Configuration registers.
	logic [31:0] min_int_q, max_int_q;
	logic [23:0] max_pw_q;
	logic [4:0]  win_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_int_q <= MIN_INTERVAL_RST;
			max_int_q <= MAX_INTERVAL_RST;
			max_pw_q  <= MAX_POWER_RST;
			win_q     <= WINDOW_LEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MIN_INTERVAL: min_int_q <= cfg_data;
				CFG_MAX_INTERVAL: max_int_q <= cfg_data;
				CFG_MAX_POWER:    max_pw_q  <= cfg_data[23:0];
				CFG_WINDOW_LEN:   win_q     <= cfg_data[4:0];
				default:          ;
			endcase
		end
	end

	// Control and item registers.
	logic [3:0]             state_q;
	logic [NUM_DOMAINS-1:0] seen_q;
	logic [2:0]             dom_q;
	logic [31:0]            en_q, de_q;
	logic [63:0]            tm_q, dt_q;
	rec_t                   rec_q, rec_rd;
	logic [HW-1:0]          pos_q;
	logic [FW-1:0]          n_q, cnt_q;
	logic [SUMW-1:0]        acc_q;
	logic [23:0]            avg_q;
	logic                   out_valid_q;

	logic [DW-1:0] didx;
	logic          in_acc, in_range;
	assign didx     = DW'(dom_q);
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign in_range = 32'(domain) < NUM_DOMAINS;

	// Divider hookup.
	logic              div_start, div_busy, div_done;
	logic [DIV_NW-1:0] div_n, div_q;
	logic [DIV_DW-1:0] div_d;

	emc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// Record memory.
	rec_t          rec_mem [NUM_DOMAINS];
	logic          rec_we;
	rec_t          rec_wd;

	always_ff @(posedge clk) begin
		if (rec_we)
			rec_mem[didx] <= rec_wd;
		rec_rd <= rec_mem[DW'(domain)];
	end

	// Ring memory.
	logic [23:0]   ring_mem [RD];
	logic [23:0]   ring_rd;
	logic          ring_we;
	logic [RW-1:0] ring_wa, ring_ra;
	logic [HW-1:0] pos_prev;

	assign pos_prev = (pos_q == '0) ? HW'(RING_DEPTH - 1) : pos_q - 1'b1;
	assign ring_wa  = RW'(32'(didx) * RING_DEPTH + 32'(rec_q.head));
	assign ring_ra  = RW'(32'(didx) * RING_DEPTH + 32'(pos_prev));

	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[ring_wa] <= div_q[23:0];
		ring_rd <= ring_mem[ring_ra];
	end

	// Sequencer combinational controls.
	logic          ok, pw_ok;
	logic [HW-1:0] head_nx;
	logic [FW-1:0] fill_nx;
	logic [7:0]    n_w;
	logic [64:0]   tot_sum;
	rec_t          rec_prev;

	always_comb begin
		ok      = (dt_q > 64'(min_int_q)) && (dt_q < 64'(max_int_q));
		pw_ok   = div_q < 64'(max_pw_q);
		head_nx = (rec_q.head == HW'(RING_DEPTH - 1)) ? '0 : rec_q.head + 1'b1;
		fill_nx = (32'(rec_q.fill) < RING_DEPTH) ? rec_q.fill + 1'b1 : rec_q.fill;
		n_w     = (win_q == '0) ? 8'd1 : 8'(win_q);
		if (32'(n_w) > RING_DEPTH)
			n_w = 8'(RING_DEPTH);
		if (n_w > 8'(fill_nx))
			n_w = 8'(fill_nx);
		tot_sum = {1'b0, rec_q.total} + 65'(de_q);
		rec_prev             = rec_q;
		rec_prev.prev_energy = en_q;
		rec_prev.prev_time   = tm_q;

		rec_we    = 1'b0;
		rec_wd    = rec_prev;
		ring_we   = 1'b0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		unique case (state_q)
			S_LOAD: begin
				if (!seen_q[didx]) begin
					rec_we    = 1'b1;
					rec_wd    = '0;
					rec_wd.prev_energy = en_q;
					rec_wd.prev_time   = tm_q;
				end
			end
			S_CHK: begin
				if (!ok)
					rec_we = 1'b1;
				else begin
					div_start = 1'b1;
					div_n     = DIV_NW'(64'(de_q) * 64'(MW_SCALE));
					div_d     = dt_q[DIV_DW-1:0];
				end
			end
			S_PDIV: begin
				if (div_done) begin
					if (!pw_ok)
						rec_we = 1'b1;
					else
						ring_we = 1'b1;
				end
			end
			S_RACC: begin
				if (cnt_q + 1'b1 == n_q) begin
					div_start = 1'b1;
					div_n     = DIV_NW'(acc_q + SUMW'(ring_rd));
					div_d     = DIV_DW'(n_q);
				end
			end
			S_SGO: begin
				rec_we    = 1'b1;
				rec_wd    = rec_q;
				div_start = 1'b1;
				div_n     = rec_q.avg_sum;
				div_d     = rec_q.avg_count;
			end
			default: ;
		endcase
	end

	// Sequencer state, seen bits and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Result held until taken; a new one loads as the old one leaves
			if (state_q == S_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_acc && in_range) state_q <= S_LOAD;
				S_LOAD: begin
					if (!seen_q[didx]) begin
						seen_q[didx] <= 1'b1;
						state_q      <= S_IDLE;
					end else
						state_q <= S_CHK;
				end
				S_CHK:  state_q <= ok ? S_PDIV : S_IDLE;
				S_PDIV: if (div_done) state_q <= pw_ok ? S_RRD : S_IDLE;
				S_RRD:  state_q <= S_RACC;
				S_RACC: state_q <= (cnt_q + 1'b1 == n_q) ? S_WDIV : S_RRD;
				S_WDIV: if (div_done) state_q <= S_SGO;
				S_SGO:  state_q <= S_SDIV;
				S_SDIV: if (div_done) state_q <= S_OUT;
				S_OUT:  if (!out_valid_q || out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				dom_q <= domain;
				en_q  <= energy_cnt;
				tm_q  <= time_us;
			end
			S_LOAD: begin
				rec_q <= rec_rd;
				de_q  <= en_q - rec_rd.prev_energy;
				dt_q  <= tm_q - rec_rd.prev_time;
			end
			S_CHK: rec_q <= rec_prev;
			S_PDIV: begin
				if (div_done) begin
					rec_q.head <= head_nx;
					rec_q.fill <= fill_nx;
					pos_q      <= head_nx;
					n_q        <= FW'(n_w);
					cnt_q      <= '0;
					acc_q      <= '0;
				end
			end
			S_RRD: pos_q <= pos_prev;
			S_RACC: begin
				acc_q <= acc_q + SUMW'(ring_rd);
				cnt_q <= cnt_q + 1'b1;
			end
			S_WDIV: begin
				if (div_done) begin
					avg_q <= div_q[23:0];
					if (rec_q.min_p == '0 || div_q[23:0] < rec_q.min_p)
						rec_q.min_p <= div_q[23:0];
					if (div_q[23:0] > rec_q.max_p)
						rec_q.max_p <= div_q[23:0];
					if (rec_q.avg_count != '1) begin
						rec_q.avg_sum   <= rec_q.avg_sum + 64'(div_q[23:0]);
						rec_q.avg_count <= rec_q.avg_count + 1'b1;
					end
					rec_q.total <= tot_sum[64] ? '1 : tot_sum[63:0];
				end
			end
			S_OUT: begin
				// Session quotient still sits in the idle divider
				if (!out_valid_q || out_ready) begin
					out_domain      <= dom_q;
					window_avg_mw   <= avg_q;
					counter_uj      <= en_q;
					min_avg_mw      <= rec_q.min_p;
					max_avg_mw      <= rec_q.max_p;
					session_avg_mw  <= div_q[23:0];
					total_energy_uj <= rec_q.total;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	// Checks.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output step");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");
	a_win_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RACC |-> cnt_q < n_q && n_q != '0)
		else $error("window count out of range");
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> $past(state_q) == S_IDLE)
		else $error("record load without item");

endmodule

// ===== dv/energy_counter_power_meter_chk.sv =====
// Checker for the energy counter power meter: watches the channels, predicts and compares.
module energy_counter_power_meter_chk import emc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  domain,
	input  logic [31:0] energy_cnt,
	input  logic [63:0] time_us,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  out_domain,
	input  logic [23:0] window_avg_mw,
	input  logic [31:0] counter_uj,
	input  logic [23:0] min_avg_mw,
	input  logic [23:0] max_avg_mw,
	input  logic [23:0] session_avg_mw,
	input  logic [63:0] total_energy_uj,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          n_pending,
	output int          n_errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DOMS  = NUM_DOMAINS_DEF;
	localparam int DEPTH = RING_DEPTH_DEF;

	typedef struct packed {
		logic [2:0]  dom;
		logic [23:0] win_avg;
		logic [31:0] counter;
		logic [23:0] min_avg;
		logic [23:0] max_avg;
		logic [23:0] sess_avg;
		logic [63:0] total;
	} reading_t;

	reading_t readings_due[$];

	// Configuration copy
	logic [31:0] lim_min_dt, lim_max_dt;
	logic [23:0] lim_power;
	logic [4:0]  win_len;

	// Per-domain meter state
	logic        seen_q    [DOMS];
	logic [31:0] last_e    [DOMS];
	logic [63:0] last_t    [DOMS];
	logic [23:0] ring      [DOMS][DEPTH];
	logic [3:0]  head      [DOMS];
	logic [4:0]  fill      [DOMS];
	logic [23:0] lo_avg    [DOMS];
	logic [23:0] hi_avg    [DOMS];
	logic [63:0] sum_avg   [DOMS];
	logic [31:0] cnt_avg   [DOMS];
	logic [63:0] acc_e     [DOMS];

	// Mean of the newest min(window, fill) readings of a domain
	function automatic logic [23:0] mean_of_window(int d);
		int n;
		int pos;
		logic [63:0] acc;
		n = (win_len == 0) ? 1 : ((win_len > DEPTH) ? DEPTH : int'(win_len));
		if (n > fill[d]) n = fill[d];
		if (n == 0) return 24'd0;
		pos = head[d];
		acc = 0;
		for (int i = 0; i < n; i++) begin
			pos = (pos == 0) ? DEPTH - 1 : pos - 1;
			acc += ring[d][pos];
		end
		return 24'(acc / n);
	endfunction

	// Work out the result, if any, of one accepted sample
	task automatic meter_sample(logic [2:0] d, logic [31:0] e, logic [63:0] t);
		logic [31:0] de;
		logic [63:0] dt, pwr;
		logic [23:0] avg;
		reading_t r;
		if (!seen_q[d]) begin
			seen_q[d] = 1'b1;
			last_e[d] = e;
			last_t[d] = t;
			head[d] = 0;
			fill[d] = 0;
			lo_avg[d] = 0;
			hi_avg[d] = 0;
			sum_avg[d] = 0;
			cnt_avg[d] = 0;
			return;
		end
		de = e - last_e[d];
		dt = t - last_t[d];
		last_e[d] = e;
		last_t[d] = t;
		if (!(dt > {32'd0, lim_min_dt} && dt < {32'd0, lim_max_dt})) return;
		pwr = ({32'd0, de} * 64'd1000) / dt;
		if (pwr >= {40'd0, lim_power}) return;
		ring[d][head[d]] = pwr[23:0];
		head[d] = head[d] + 4'd1;
		if (fill[d] < DEPTH) fill[d] = fill[d] + 5'd1;
		avg = mean_of_window(d);
		if (lo_avg[d] == 0 || avg < lo_avg[d]) lo_avg[d] = avg;
		if (avg > hi_avg[d]) hi_avg[d] = avg;
		if (cnt_avg[d] != 32'hFFFF_FFFF) begin
			sum_avg[d] += avg;
			cnt_avg[d] += 1;
		end
		if (acc_e[d] > 64'hFFFF_FFFF_FFFF_FFFF - de) acc_e[d] = 64'hFFFF_FFFF_FFFF_FFFF;
		else acc_e[d] += de;
		r.dom = d;
		r.win_avg = avg;
		r.counter = e;
		r.min_avg = lo_avg[d];
		r.max_avg = hi_avg[d];
		r.sess_avg = (cnt_avg[d] != 0) ? 24'(sum_avg[d] / cnt_avg[d]) : 24'd0;
		r.total = acc_e[d];
		readings_due.insert(readings_due.size(), r);
	endtask

	task automatic note_miss(string fld, logic [63:0] want, logic [63:0] got);
		n_errors++;
		if (n_errors <= 10)
			$display("%0t: %s expected %0d got %0d", $realtime, fld, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t w;
		if (!arst_n) begin
			lim_min_dt = MIN_INTERVAL_RST;
			lim_max_dt = MAX_INTERVAL_RST;
			lim_power = MAX_POWER_RST;
			win_len = WINDOW_LEN_RST;
			for (int d = 0; d < DOMS; d++) begin
				seen_q[d] = 0;
				head[d] = 0;
				fill[d] = 0;
				lo_avg[d] = 0;
				hi_avg[d] = 0;
				sum_avg[d] = 0;
				cnt_avg[d] = 0;
				acc_e[d] = 0;
			end
			readings_due.delete();
			n_errors = 0;
		end else begin
			// Result channel
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					note_miss("unexpected result, domain", 0, out_domain);
				end else begin
					w = readings_due.pop_front();
					if (out_domain != w.dom) note_miss("out_domain", w.dom, out_domain);
					if (window_avg_mw != w.win_avg)
						note_miss("window_avg_mw", w.win_avg, window_avg_mw);
					if (counter_uj != w.counter) note_miss("counter_uj", w.counter, counter_uj);
					if (min_avg_mw != w.min_avg) note_miss("min_avg_mw", w.min_avg, min_avg_mw);
					if (max_avg_mw != w.max_avg) note_miss("max_avg_mw", w.max_avg, max_avg_mw);
					if (session_avg_mw != w.sess_avg)
						note_miss("session_avg_mw", w.sess_avg, session_avg_mw);
					if (total_energy_uj != w.total)
						note_miss("total_energy_uj", w.total, total_energy_uj);
				end
			end
			// Register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN_INTERVAL: lim_min_dt = cfg_data;
					CFG_MAX_INTERVAL: lim_max_dt = cfg_data;
					CFG_MAX_POWER:    lim_power = cfg_data[23:0];
					CFG_WINDOW_LEN:   win_len = cfg_data[4:0];
					default: ;
				endcase
			end
			// Sample channel
			if (in_valid && in_ready) meter_sample(domain, energy_cnt, time_us);
		end
		n_pending = readings_due.size();
	end

endmodule

// ===== dv/energy_counter_power_meter_tb.sv =====
// Testbench top for the energy counter power meter: stimulus, stalls and verdict.
module energy_counter_power_meter_tb import emc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE      = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0, in_ready;
	logic [2:0]  domain = '0;
	logic [31:0] energy_cnt = '0;
	logic [63:0] time_us = '0;
	logic        out_valid, out_ready = 1'b1;
	logic [2:0]  out_domain;
	logic [23:0] window_avg_mw, min_avg_mw, max_avg_mw, session_avg_mw;
	logic [31:0] counter_uj;
	logic [63:0] total_energy_uj;
	logic        cfg_valid = 1'b0, cfg_ready;
	logic [1:0]  cfg_index = CFG_MIN_INTERVAL;
	logic [31:0] cfg_data = '0;
	int          n_pending, n_errors;
	int          cycles = 0;

	// Shadow of the limits and of each domain's last sample, for shaping stimulus
	logic [31:0] sh_min = MIN_INTERVAL_RST, sh_max = MAX_INTERVAL_RST;
	logic [23:0] sh_pwr = MAX_POWER_RST;
	logic [31:0] cur_e [8];
	logic [63:0] cur_t [8];
	int          burst_left = 0;
	int          quiet = 0;
	logic [15:0] stall_pat = '1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	energy_counter_power_meter i_dut (.*);

	energy_counter_power_meter_chk i_chk (.*);

	// Receiver stall pattern, reshuffled now and then
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 512 == 0)
			stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0101;
		else
			stall_pat <= {stall_pat[14:0], stall_pat[15]};
		out_ready <= stall_pat[15];
		if (cycles > CYCLE_LIMIT) begin
			$display("energy_counter_power_meter: mismatch");
			$finish;
		end
	end

	task automatic send_sample(logic [2:0] d, logic [31:0] e, logic [63:0] t);
		in_valid <= 1'b1;
		domain <= d;
		energy_cnt <= e;
		time_us <= t;
		cur_e[d] = e;
		cur_t[d] = t;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		// Burst and gap handling
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			if (quiet == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	// Wait until idle, with the block's longest no-result latency on top
	task automatic drain;
		in_valid <= 1'b0;
		do @(negedge clk); while (n_pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_MIN_INTERVAL: sh_min = val;
			CFG_MAX_INTERVAL: sh_max = val;
			CFG_MAX_POWER:    sh_pwr = val[23:0];
			default: ;
		endcase
	endtask

	task automatic set_limits(logic [31:0] mn, logic [31:0] mx, logic [31:0] pw,
			logic [31:0] wl);
		drain();
		write_reg(CFG_MIN_INTERVAL, mn);
		write_reg(CFG_MAX_INTERVAL, mx);
		write_reg(CFG_MAX_POWER, pw);
		write_reg(CFG_WINDOW_LEN, wl);
	endtask

	// Mostly a plausible next sample of a domain, sometimes noise
	task automatic random_sample;
		logic [2:0]  d;
		logic [63:0] lo, hi, dt, p, de;
		d = 3'($urandom_range(0, 7));
		lo = {32'd0, sh_min} + 1;
		hi = (sh_max == 0) ? 64'd0 : {32'd0, sh_max} - 1;
		if ($urandom_range(0, 9) < 8 && hi >= lo) begin
			dt = lo + ({$urandom, $urandom} % (hi - lo + 1));
			p = (sh_pwr == 0) ? 64'd0 : 64'($urandom_range(0, sh_pwr - 1));
			if ($urandom_range(0, 3) == 0) p = p % 64;
			de = p * dt / 1000;
			if (de > 64'hFFFF_FFFF) de = {32'd0, $urandom};
			send_sample(d, cur_e[d] + de[31:0], cur_t[d] + dt);
		end else begin
			case ($urandom_range(0, 2))
				0: send_sample(d, $urandom, {$urandom, $urandom});
				1: send_sample(d, $urandom, cur_t[d] + $urandom_range(0, 3));
				default: send_sample(d, $urandom, cur_t[d] + {32'd0, $urandom});
			endcase
		end
	endtask

	task automatic random_run(int n);
		quiet = ($urandom_range(0, 2) == 0);
		repeat (n) random_sample();
		quiet = 0;
	endtask

	initial begin
		for (int d = 0; d < 8; d++) begin
			cur_e[d] = '0;
			cur_t[d] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset limits, first samples, bounds, wraps, zero minimum
		send_sample(3'd0, 32'd0, 64'd0);
		send_sample(3'd0, 32'd5000, 64'd200000);
		send_sample(3'd0, 32'd6000, 64'd300000);
		send_sample(3'd0, 32'd7000, 64'd10300000);
		send_sample(3'd0, 32'd8000, 64'd10399999);
		send_sample(3'd0, 32'd200008000, 64'd10599999);
		send_sample(3'd0, 32'd400007999, 64'd10799999);
		send_sample(3'd1, 32'hFFFF_FF00, 64'hFFFF_FFFF_FFFF_0000);
		send_sample(3'd1, 32'h0000_0100, 64'h0000_0000_0002_0D40);
		send_sample(3'd1, 32'hFFFF_FFFF, 64'h0000_0000_0006_0D40);
		send_sample(3'd2, 32'd1000, 64'd1000000);
		send_sample(3'd2, 32'd1000, 64'd1200000);
		send_sample(3'd2, 32'd1000, 64'd1400000);
		send_sample(3'd2, 32'd50000, 64'd1600000);
		send_sample(3'd2, 32'd50010, 64'd1800000);
		for (int d = 3; d < 8; d++) begin
			send_sample(3'(d), 32'(d * 1000), 64'(d));
			send_sample(3'(d), 32'(d * 1000 + 777), 64'(d + 150000));
		end

		// Wide limits, full window
		set_limits(32'd0, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'd16);
		random_run(300);
		// Pause until every result is out, then go on
		drain();
		random_run(150);
		// Tight limits, window of one
		set_limits(32'd50, 32'd5000, 32'd5000, 32'd1);
		random_run(300);
		// Window of zero acts as one; oversize acts as the full ring
		set_limits(32'd1000, 32'd2000000, 32'd800000, 32'd0);
		random_run(120);
		set_limits(32'd1000, 32'd2000000, 32'd800000, 32'd17);
		random_run(120);
		set_limits(32'd1000, 32'd2000000, 32'd800000, 32'd31);
		random_run(120);
		// Limits that reject every sample
		set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'd5);
		random_run(40);
		set_limits(32'd0, 32'd0, 32'h00FF_FFFF, 32'd5);
		random_run(30);
		set_limits(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd5);
		random_run(30);
		// Back to the reset limits
		set_limits(MIN_INTERVAL_RST, MAX_INTERVAL_RST, MAX_POWER_RST, WINDOW_LEN_RST);
		random_run(150);

		drain();
		if (n_errors == 0)
			$display("energy_counter_power_meter: match");
		else
			$display("energy_counter_power_meter: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/emc_pkg.sv
rtl/core/emc_div.sv
rtl/core/energy_counter_power_meter.sv
dv/energy_counter_power_meter_chk.sv
dv/energy_counter_power_meter_tb.sv
